/* src/bs_pkg.sv */
`default_nettype none
package bs_pkg;

  localparam int BATCH_SIZE = 6;

  localparam int SAMPLE_W  = 16;
  localparam int VAR_W     = 40;
  localparam int COUNT_W   = 3;
  localparam int FRAC_W    = 8;
  localparam int IDX_W     = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int ISSUE_W   = $clog2(BATCH_SIZE + 1);
  localparam int CNT_W     = ($clog2(BATCH_SIZE + 1) > COUNT_W) ?
                             $clog2(BATCH_SIZE + 1) : COUNT_W;
  localparam int SUM_W     = SAMPLE_W + $clog2(BATCH_SIZE);
  localparam int SQ_W      = 2 * SAMPLE_W + $clog2(BATCH_SIZE);
  localparam int NUM_W     = SQ_W + FRAC_W;
  localparam int REM_W     = $clog2(BATCH_SIZE);

  // digit-serial division by the batch size, one CHUNK_W-bit digit per cycle
  localparam int CHUNK_W    = 16;
  localparam int MEAN_STEPS = (SUM_W + CHUNK_W - 1) / CHUNK_W;
  localparam int VAR_STEPS  = (NUM_W + CHUNK_W - 1) / CHUNK_W;
  localparam int MEAN_W     = MEAN_STEPS * CHUNK_W;
  localparam int DIV_W      = VAR_STEPS * CHUNK_W;
  localparam int DVD_W      = REM_W + CHUNK_W;
  localparam int RECIP_SH   = CHUNK_W + 2 * REM_W;
  localparam int RECIP      = (2 ** RECIP_SH + BATCH_SIZE - 1) / BATCH_SIZE;
  localparam int RECIP_W    = $clog2(RECIP + 1);
  localparam int PROD_W     = DVD_W + RECIP_W;
  localparam int STEP_W     = $clog2(VAR_STEPS + 1);

  typedef struct packed {
    logic start;
    logic mode_var;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* src/batch_statistics.sv */
// Batch statistics over BATCH_SIZE signed 16-bit samples. While a batch
// loads, a sample is taken whenever in_valid is high; the last of a batch
// starts the statistics pass and holds in_stall high until the result sits
// in the output register. That pass runs a reciprocal-multiply divider that
// retires one 16-bit quotient digit per cycle twice (MEAN_STEPS digits for
// the mean, VAR_STEPS for the variance) and reads the sample memory once per
// stored sample through a three-stage square and accumulate pipeline.
// The mean truncates toward zero; the variance uses that integer mean and
// carries 8 fraction bits. Sign counts wrap to 3 bits. A new batch loads
// while the previous result still waits on out_stall.
`default_nettype none
module batch_statistics (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic signed [bs_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  output logic signed [bs_pkg::SAMPLE_W-1:0]     minimum,
  output logic signed [bs_pkg::SAMPLE_W-1:0]     maximum,
  output logic signed [bs_pkg::SAMPLE_W-1:0]     mean,
  output logic        [bs_pkg::VAR_W-1:0]        variance,
  output logic        [bs_pkg::COUNT_W-1:0]      negatives,
  output logic        [bs_pkg::COUNT_W-1:0]      zeros,
  output logic        [bs_pkg::COUNT_W-1:0]      positives,
  output logic                                   out_valid,
  input  wire logic                              out_stall
);
  import bs_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD   = 7'b0000001,
    S_MSTART = 7'b0000010,
    S_MEAN   = 7'b0000100,
    S_PASS   = 7'b0001000,
    S_VSTART = 7'b0010000,
    S_VAR    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  logic [IDX_W-1:0]          fill;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [SUM_W-1:0]   run_sum;
  logic [CNT_W-1:0]          neg_cnt;
  logic [CNT_W-1:0]          zero_cnt;
  logic [CNT_W-1:0]          pos_cnt;
  logic                      sum_neg;
  logic signed [SAMPLE_W-1:0] mean_r;

  logic [ISSUE_W-1:0]        issue;
  logic                      rd_valid;
  logic                      a_valid;
  logic                      b_valid;
  logic [SAMPLE_W-1:0]       ad;
  logic [2*SAMPLE_W-1:0]     sq;
  logic [SQ_W-1:0]           sq_sum;

  logic                      in_acc;
  logic                      out_free;
  logic                      last;
  logic [SUM_W-1:0]          sum_abs;
  logic [SAMPLE_W:0]         mean_q;
  logic [SAMPLE_W:0]         mean_s;
  logic signed [SAMPLE_W:0]  diff;
  logic [SAMPLE_W:0]         diff_abs;
  logic [SAMPLE_W-1:0]       rdata;
  logic                      issuing;

  div_ctrl_t                 div_ctrl;
  div_stat_t                 div_stat;
  logic [NUM_W-1:0]          div_num;
  logic [NUM_W-1:0]          div_q;

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last     = (fill == IDX_W'(BATCH_SIZE - 1));
  assign issuing  = (state == S_PASS) && (issue < ISSUE_W'(BATCH_SIZE));

  always_comb begin
    sum_abs  = run_sum[SUM_W-1] ? SUM_W'(-run_sum) : SUM_W'(run_sum);
    mean_q   = div_q[SAMPLE_W:0];
    mean_s   = sum_neg ? (SAMPLE_W+1)'(-mean_q) : mean_q;
    diff     = $signed({rdata[SAMPLE_W-1], rdata}) - $signed({mean_r[SAMPLE_W-1], mean_r});
    diff_abs = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
  end

  always_comb begin
    div_ctrl.start    = (state == S_MSTART) || (state == S_VSTART);
    div_ctrl.mode_var = (state == S_VSTART);
    div_num = (state == S_VSTART) ? {sq_sum, {FRAC_W{1'b0}}} : NUM_W'(sum_abs);
  end

  bs_ram #(
    .DEPTH(BATCH_SIZE),
    .WIDTH(SAMPLE_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (in_acc),
    .waddr(fill),
    .wdata(sample),
    .raddr(issue[IDX_W-1:0]),
    .rdata(rdata)
  );

  bs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .numerator(div_num),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      run_min   <= '0;
      run_max   <= '0;
      run_sum   <= '0;
      neg_cnt   <= '0;
      zero_cnt  <= '0;
      pos_cnt   <= '0;
      issue     <= '0;
      rd_valid  <= 1'b0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= issuing;
      a_valid  <= rd_valid;
      b_valid  <= a_valid;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (fill == '0) begin
              run_min <= sample;
              run_max <= sample;
            end else begin
              if (sample < run_min) run_min <= sample;
              if (sample > run_max) run_max <= sample;
            end
            run_sum <= run_sum + SUM_W'(sample);
            if (sample < 0) begin
              neg_cnt <= neg_cnt + CNT_W'(1);
            end else if (sample == 0) begin
              zero_cnt <= zero_cnt + CNT_W'(1);
            end else begin
              pos_cnt <= pos_cnt + CNT_W'(1);
            end
            if (last) begin
              fill  <= '0;
              state <= S_MSTART;
            end else begin
              fill <= fill + IDX_W'(1);
            end
          end
        end
        S_MSTART: begin
          state <= S_MEAN;
        end
        S_MEAN: begin
          if (div_stat.done) begin
            issue <= '0;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          if (issuing) begin
            issue <= issue + ISSUE_W'(1);
          end else if (!rd_valid && !a_valid && !b_valid) begin
            state <= S_VSTART;
          end
        end
        S_VSTART: begin
          state <= S_VAR;
        end
        S_VAR: begin
          if (div_stat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            run_min   <= '0;
            run_max   <= '0;
            run_sum   <= '0;
            neg_cnt   <= '0;
            zero_cnt  <= '0;
            pos_cnt   <= '0;
            state     <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // payload: mean, square pipeline, result registers
  always_ff @(posedge clk) begin
    if (state == S_MSTART) begin
      sum_neg <= run_sum[SUM_W-1];
    end
    if (state == S_MEAN && div_stat.done) begin
      mean_r <= mean_s[SAMPLE_W-1:0];
      sq_sum <= '0;
    end
    if (rd_valid) begin
      ad <= diff_abs[SAMPLE_W-1:0];
    end
    if (a_valid) begin
      sq <= ad * ad;
    end
    if (b_valid) begin
      sq_sum <= sq_sum + SQ_W'(sq);
    end
    if (state == S_DONE && out_free) begin
      minimum   <= run_min;
      maximum   <= run_max;
      mean      <= mean_r;
      variance  <= div_q[VAR_W-1:0];
      negatives <= neg_cnt[COUNT_W-1:0];
      zeros     <= zero_cnt[COUNT_W-1:0];
      positives <= pos_cnt[COUNT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= IDX_W'(BATCH_SIZE - 1)) else $error("fill index out of range");
  a_pipe_in_pass: assert property (@(posedge clk) disable iff (rst)
    (rd_valid || a_valid || b_valid) |-> state == S_PASS)
    else $error("square pipeline active outside the pass");
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_MEAN || state == S_VAR))
    else $error("divider finished in an unexpected state");
  a_result_after_var: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the final state");
`endif

endmodule
`default_nettype wire

/* src/bs_ram.sv */
`default_nettype none
module bs_ram #(
  parameter int DEPTH = 6,
  parameter int WIDTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/bs_div.sv */
`default_nettype none
module bs_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire bs_pkg::div_ctrl_t       ctrl,
  input  wire logic [bs_pkg::NUM_W-1:0] numerator,
  output bs_pkg::div_stat_t            stat,
  output logic [bs_pkg::NUM_W-1:0]     quotient
);
  import bs_pkg::*;

  logic [DIV_W-1:0]  num_sh;
  logic [DIV_W-1:0]  quo_sh;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [DVD_W-1:0]  dvd;
  logic [PROD_W-1:0] prod;
  logic [CHUNK_W-1:0] qchunk;
  logic [DVD_W-1:0]  back;

  // long division by the batch size, one 16-bit digit per cycle; the digit
  // comes from a multiply by the rounded-up reciprocal, exact for any
  // partial dividend below BATCH_SIZE * 2**CHUNK_W
  always_comb begin
    dvd    = {rem, num_sh[DIV_W-1 -: CHUNK_W]};
    prod   = PROD_W'(dvd) * PROD_W'(RECIP);
    qchunk = prod[RECIP_SH +: CHUNK_W];
    back   = dvd - DVD_W'(qchunk) * DVD_W'(BATCH_SIZE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        steps <= ctrl.mode_var ? STEP_W'(VAR_STEPS) : STEP_W'(MEAN_STEPS);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      // mean mode: left-align the narrower numerator
      num_sh <= ctrl.mode_var ? DIV_W'(numerator) :
                {numerator[MEAN_W-1:0], {(DIV_W-MEAN_W){1'b0}}};
      rem    <= '0;
      quo_sh <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[DIV_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      rem    <= back[REM_W-1:0];
      quo_sh <= {quo_sh[DIV_W-CHUNK_W-1:0], qchunk};
    end
  end

  assign quotient  = quo_sh[NUM_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !busy) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("done without a finished run");
  a_steps_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> steps != '0) else $error("busy with no steps left");
`endif

endmodule
`default_nettype wire
